// ===== rtl/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdec_pkg
// types and encodings shared by the rv32i instruction decoder
// ----------------------------------------------------------------------------
package rvdec_pkg;

   // major opcodes, bits 6..0 of the word
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct7 values that select the base and the alternate alu operation
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // whole words of the two environment calls
   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   // instruction identifiers
   localparam logic [5:0] OP_ILLEGAL = 6'd0;
   localparam logic [5:0] OP_LUI     = 6'd1;
   localparam logic [5:0] OP_AUIPC   = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_JALR    = 6'd4;
   localparam logic [5:0] OP_BEQ     = 6'd5;
   localparam logic [5:0] OP_BNE     = 6'd6;
   localparam logic [5:0] OP_BLT     = 6'd7;
   localparam logic [5:0] OP_BGE     = 6'd8;
   localparam logic [5:0] OP_BLTU    = 6'd9;
   localparam logic [5:0] OP_BGEU    = 6'd10;
   localparam logic [5:0] OP_LB      = 6'd11;
   localparam logic [5:0] OP_LH      = 6'd12;
   localparam logic [5:0] OP_LW      = 6'd13;
   localparam logic [5:0] OP_LBU     = 6'd14;
   localparam logic [5:0] OP_LHU     = 6'd15;
   localparam logic [5:0] OP_SB      = 6'd16;
   localparam logic [5:0] OP_SH      = 6'd17;
   localparam logic [5:0] OP_SW      = 6'd18;
   localparam logic [5:0] OP_ADDI    = 6'd19;
   localparam logic [5:0] OP_SLTI    = 6'd20;
   localparam logic [5:0] OP_SLTIU   = 6'd21;
   localparam logic [5:0] OP_XORI    = 6'd22;
   localparam logic [5:0] OP_ORI     = 6'd23;
   localparam logic [5:0] OP_ANDI    = 6'd24;
   localparam logic [5:0] OP_SLLI    = 6'd25;
   localparam logic [5:0] OP_SRLI    = 6'd26;
   localparam logic [5:0] OP_SRAI    = 6'd27;
   localparam logic [5:0] OP_ADD     = 6'd28;
   localparam logic [5:0] OP_SUB     = 6'd29;
   localparam logic [5:0] OP_SLL     = 6'd30;
   localparam logic [5:0] OP_SLT     = 6'd31;
   localparam logic [5:0] OP_SLTU    = 6'd32;
   localparam logic [5:0] OP_XOR     = 6'd33;
   localparam logic [5:0] OP_SRL     = 6'd34;
   localparam logic [5:0] OP_SRA     = 6'd35;
   localparam logic [5:0] OP_OR      = 6'd36;
   localparam logic [5:0] OP_AND     = 6'd37;
   localparam logic [5:0] OP_ECALL   = 6'd38;
   localparam logic [5:0] OP_EBREAK  = 6'd39;
   localparam logic [5:0] OP_CSRRW   = 6'd40;
   localparam logic [5:0] OP_CSRRS   = 6'd41;
   localparam logic [5:0] OP_CSRRC   = 6'd42;
   localparam logic [5:0] OP_CSRRWI  = 6'd43;
   localparam logic [5:0] OP_CSRRSI  = 6'd44;
   localparam logic [5:0] OP_CSRRCI  = 6'd45;

   typedef struct packed {
      logic [31:0] insn_word;
      logic [31:0] insn_addr;
   } req_type;

   typedef struct packed {
      logic [5:0]         op_id;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic signed [31:0] immediate;
      logic [11:0]        csr_number;
      logic [31:0]        target_addr;
   } rsp_type;

endpackage

// ===== rtl/rv32i_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// classifies one rv32i instruction word and extracts its fields
// ----------------------------------------------------------------------------
//
//   channel    ports                      direction  handshake
//   --------   ------------------------   ---------  -------------------------
//   request    start, busy, req_data      in         taken when start && !busy
//   response   rsp_strobe, rsp_data       out        one cycle, cannot stall
//
// one transaction is taken in every clock cycle; busy is always low
// rsp_strobe and the response come from the result register; the path runs
//   through an input register, then the decode and the 32-bit target adder,
//   then the result register
// the adder from the input register to the result register sets the clock rate
// reset clears both valid flags; payload registers are not reset
// there is no back-pressure, so nothing ever stalls inside the block
//
module rv32i_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rvdec_pkg::req_type req_data,
   output logic               rsp_strobe,
   output rvdec_pkg::rsp_type rsp_data
);

   // input register
   logic               req_valid_ff;
   logic               req_valid_in;
   rvdec_pkg::req_type req_data_ff;

   // result register
   logic               rsp_valid_ff;
   rvdec_pkg::rsp_type rsp_data_ff;
   rvdec_pkg::rsp_type rsp_data_in;

   // decode signals
   logic [31:0] word;
   logic [31:0] addr;
   logic [6:0]  opc;
   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_u;
   logic [31:0] imm_shamt;
   logic [31:0] target_b;
   logic [31:0] target_j;
   logic [5:0]  op_sel;
   logic [31:0] imm_sel;
   logic [31:0] target_sel;

   // the decoder never holds requests off
   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_data_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // field extraction
   assign word   = req_data_ff.insn_word;
   assign addr   = req_data_ff.insn_addr;
   assign opc    = word[6:0];
   assign funct3 = word[14:12];
   assign funct7 = word[31:25];

   // immediates of each format, sign taken from bit 31; the shift amount is zero-extended
   assign imm_i     = {{20{word[31]}}, word[31:20]};
   assign imm_s     = {{20{word[31]}}, word[31:25], word[11:7]};
   assign imm_b     = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
   assign imm_j     = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
   assign imm_u     = {word[31:12], 12'h000};
   assign imm_shamt = {27'd0, word[24:20]};

   // both targets wrap modulo 2^32
   assign target_b = addr + imm_b;
   assign target_j = addr + imm_j;

   // classification; illegal words leave immediate and target at zero
   always_comb begin
      op_sel     = rvdec_pkg::OP_ILLEGAL;
      imm_sel    = 32'd0;
      target_sel = 32'd0;
      unique case (opc)
         rvdec_pkg::OPC_LUI: begin
            op_sel  = rvdec_pkg::OP_LUI;
            imm_sel = imm_u;
         end
         rvdec_pkg::OPC_AUIPC: begin
            op_sel  = rvdec_pkg::OP_AUIPC;
            imm_sel = imm_u;
         end
         rvdec_pkg::OPC_JAL: begin
            op_sel     = rvdec_pkg::OP_JAL;
            imm_sel    = imm_j;
            target_sel = target_j;
         end
         rvdec_pkg::OPC_JALR: begin
            // funct3 not checked
            op_sel  = rvdec_pkg::OP_JALR;
            imm_sel = imm_i;
         end
         rvdec_pkg::OPC_BRANCH: begin
            unique case (funct3)
               3'd0:    op_sel = rvdec_pkg::OP_BEQ;
               3'd1:    op_sel = rvdec_pkg::OP_BNE;
               3'd4:    op_sel = rvdec_pkg::OP_BLT;
               3'd5:    op_sel = rvdec_pkg::OP_BGE;
               3'd6:    op_sel = rvdec_pkg::OP_BLTU;
               3'd7:    op_sel = rvdec_pkg::OP_BGEU;
               default: op_sel = rvdec_pkg::OP_ILLEGAL;
            endcase
            if (op_sel != rvdec_pkg::OP_ILLEGAL) begin
               imm_sel    = imm_b;
               target_sel = target_b;
            end
         end
         rvdec_pkg::OPC_LOAD: begin
            unique case (funct3)
               3'd0:    op_sel = rvdec_pkg::OP_LB;
               3'd1:    op_sel = rvdec_pkg::OP_LH;
               3'd2:    op_sel = rvdec_pkg::OP_LW;
               3'd4:    op_sel = rvdec_pkg::OP_LBU;
               3'd5:    op_sel = rvdec_pkg::OP_LHU;
               default: op_sel = rvdec_pkg::OP_ILLEGAL;
            endcase
            if (op_sel != rvdec_pkg::OP_ILLEGAL) begin
               imm_sel = imm_i;
            end
         end
         rvdec_pkg::OPC_STORE: begin
            unique case (funct3)
               3'd0:    op_sel = rvdec_pkg::OP_SB;
               3'd1:    op_sel = rvdec_pkg::OP_SH;
               3'd2:    op_sel = rvdec_pkg::OP_SW;
               default: op_sel = rvdec_pkg::OP_ILLEGAL;
            endcase
            if (op_sel != rvdec_pkg::OP_ILLEGAL) begin
               imm_sel = imm_s;
            end
         end
         rvdec_pkg::OPC_OPIMM: begin
            unique case (funct3)
               3'd0: begin
                  op_sel  = rvdec_pkg::OP_ADDI;
                  imm_sel = imm_i;
               end
               3'd1: begin
                  // slli takes any funct7
                  op_sel  = rvdec_pkg::OP_SLLI;
                  imm_sel = imm_shamt;
               end
               3'd2: begin
                  op_sel  = rvdec_pkg::OP_SLTI;
                  imm_sel = imm_i;
               end
               3'd3: begin
                  op_sel  = rvdec_pkg::OP_SLTIU;
                  imm_sel = imm_i;
               end
               3'd4: begin
                  op_sel  = rvdec_pkg::OP_XORI;
                  imm_sel = imm_i;
               end
               3'd5: begin
                  if (funct7 == rvdec_pkg::F7_BASE) begin
                     op_sel  = rvdec_pkg::OP_SRLI;
                     imm_sel = imm_shamt;
                  end else if (funct7 == rvdec_pkg::F7_ALT) begin
                     op_sel  = rvdec_pkg::OP_SRAI;
                     imm_sel = imm_shamt;
                  end
               end
               3'd6: begin
                  op_sel  = rvdec_pkg::OP_ORI;
                  imm_sel = imm_i;
               end
               default: begin
                  op_sel  = rvdec_pkg::OP_ANDI;
                  imm_sel = imm_i;
               end
            endcase
         end
         rvdec_pkg::OPC_OP: begin
            // only add/sub and srl/sra look at funct7
            unique case (funct3)
               3'd0: begin
                  if (funct7 == rvdec_pkg::F7_BASE) begin
                     op_sel = rvdec_pkg::OP_ADD;
                  end else if (funct7 == rvdec_pkg::F7_ALT) begin
                     op_sel = rvdec_pkg::OP_SUB;
                  end
               end
               3'd1:    op_sel = rvdec_pkg::OP_SLL;
               3'd2:    op_sel = rvdec_pkg::OP_SLT;
               3'd3:    op_sel = rvdec_pkg::OP_SLTU;
               3'd4:    op_sel = rvdec_pkg::OP_XOR;
               3'd5: begin
                  if (funct7 == rvdec_pkg::F7_BASE) begin
                     op_sel = rvdec_pkg::OP_SRL;
                  end else if (funct7 == rvdec_pkg::F7_ALT) begin
                     op_sel = rvdec_pkg::OP_SRA;
                  end
               end
               3'd6:    op_sel = rvdec_pkg::OP_OR;
               default: op_sel = rvdec_pkg::OP_AND;
            endcase
         end
         rvdec_pkg::OPC_SYSTEM: begin
            // ecall and ebreak match the whole word
            if (word == rvdec_pkg::WORD_ECALL) begin
               op_sel = rvdec_pkg::OP_ECALL;
            end else if (word == rvdec_pkg::WORD_EBREAK) begin
               op_sel = rvdec_pkg::OP_EBREAK;
            end else begin
               unique case (funct3)
                  3'd1:    op_sel = rvdec_pkg::OP_CSRRW;
                  3'd2:    op_sel = rvdec_pkg::OP_CSRRS;
                  3'd3:    op_sel = rvdec_pkg::OP_CSRRC;
                  3'd5:    op_sel = rvdec_pkg::OP_CSRRWI;
                  3'd6:    op_sel = rvdec_pkg::OP_CSRRSI;
                  3'd7:    op_sel = rvdec_pkg::OP_CSRRCI;
                  default: op_sel = rvdec_pkg::OP_ILLEGAL;
               endcase
            end
         end
         default: begin
            op_sel = rvdec_pkg::OP_ILLEGAL;
         end
      endcase
   end

   // register and csr fields pass through raw, even for illegal words
   always_comb begin
      rsp_data_in.op_id       = op_sel;
      rsp_data_in.dest_reg    = word[11:7];
      rsp_data_in.src1_reg    = word[19:15];
      rsp_data_in.src2_reg    = word[24:20];
      rsp_data_in.immediate   = $signed(imm_sel);
      rsp_data_in.csr_number  = word[31:20];
      rsp_data_in.target_addr = target_sel;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
